// ===== design/content_type_header_parser_unit_defines.svh =====
`ifndef CONTENT_TYPE_HEADER_PARSER_UNIT_DEFINES_SVH
`define CONTENT_TYPE_HEADER_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk while out of reset
`define CTP_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ctp: same-cycle check failed");

// next-cycle implication
`define CTP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ctp: next-cycle check failed");

`endif

// ===== design/ctp_pkg.sv =====
`timescale 1ns / 1ps

package ctp_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef enum logic [13:0] {
    PH_LEAD     = 14'h0001,
    PH_TYPE     = 14'h0002,
    PH_TYPE_WS  = 14'h0004,
    PH_SUB_LEAD = 14'h0008,
    PH_SUB      = 14'h0010,
    PH_SUB_WS   = 14'h0020,
    PH_PAR_LEAD = 14'h0040,
    PH_KEY      = 14'h0080,
    PH_KEY_WS   = 14'h0100,
    PH_VAL_LEAD = 14'h0200,
    PH_TOKVAL   = 14'h0400,
    PH_QUOTED   = 14'h0800,
    PH_ESC      = 14'h1000,
    PH_VAL_WS   = 14'h2000
  } ctp_phase_t;

  typedef enum logic [2:0] {
    ROLE_SKIP = 3'd0,
    ROLE_TYPE = 3'd1,
    ROLE_SUB  = 3'd2,
    ROLE_KEY  = 3'd3,
    ROLE_VAL  = 3'd4
  } ctp_role_t;

  typedef enum logic [1:0] {
    CLOSE_NONE  = 2'd0,
    CLOSE_MEDIA = 2'd1,
    CLOSE_PARAM = 2'd2
  } ctp_close_t;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_OK    = 2'd1,
    ST_MEDIA = 2'd2,
    ST_PARAM = 2'd3
  } ctp_status_t;

  typedef struct packed {
    logic tok;
    logic ws;
    logic slash;
    logic semi;
    logic eq;
    logic quote;
    logic bslash;
    logic crlf;
    logic star;
  } ctp_cls_t;

  typedef struct packed {
    logic [7:0]  och;
    logic        valid;
    ctp_role_t   role;
    ctp_close_t  closes;
    ctp_status_t status;
    logic        final_byte;
  } ctp_res_t;

  function automatic logic [7:0] ctp_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== design/ctp_in_if.sv =====
`timescale 1ns / 1ps

interface ctp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

// ===== design/ctp_out_if.sv =====
`timescale 1ns / 1ps

interface ctp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_valid;
  logic [2:0] char_role;
  logic [1:0] closes_field;
  logic [1:0] parse_status;
  logic       is_final;

  modport source (
    output valid, output out_char, output out_valid, output char_role,
    output closes_field, output parse_status, output is_final, input ready
  );
  modport sink (
    input valid, input out_char, input out_valid, input char_role,
    input closes_field, input parse_status, input is_final, output ready
  );
endinterface

// ===== design/content_type_header_parser_unit.sv =====
`timescale 1ns / 1ps
// Streaming Content-Type parser: takes one header byte per word and returns one
// tagged word per byte (character, role, field-close mark, status), in order.
// A byte passes an input register and then a result register, and a new byte is
// taken every cycle while the result side keeps up; the per-byte phase and sticky
// error are updated by the parse state machine as a byte moves to the result
// register. Status 1 or an error code appears with the byte marked is_last, and the
// next byte starts a fresh header.

`include "content_type_header_parser_unit_defines.svh"

module content_type_header_parser_unit
  import ctp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ctp_in_if.sink    in_ch,
  ctp_out_if.source out_ch
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       out_vld_r, out_vld_nxt;
  ctp_res_t   res_r;
  ctp_res_t   res;
  ctp_cls_t   cls;
  logic       advance;
  logic       take;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt  = take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    out_vld_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.in_byte;
      last_r <= in_ch.is_last;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  ctp_classify u_classify (
    .byte_i (byte_r),
    .cls_o  (cls)
  );

  ctp_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (advance),
    .byte_i (byte_r),
    .last_i (last_r),
    .cls_i  (cls),
    .res_o  (res)
  );

  assign out_ch.valid        = out_vld_r;
  assign out_ch.out_char     = res_r.och;
  assign out_ch.out_valid    = res_r.valid;
  assign out_ch.char_role    = res_r.role;
  assign out_ch.closes_field = res_r.closes;
  assign out_ch.parse_status = res_r.status;
  assign out_ch.is_final     = res_r.final_byte;

  `CTP_ASSERT_NOW(a_stall_means_full, !in_ch.ready, in_vld_r && out_vld_r)
  `CTP_ASSERT_NEXT(a_advance_fills_out, advance, out_vld_r)
  `CTP_ASSERT_NOW(a_error_quiet, out_ch.valid && out_ch.parse_status[1], !out_ch.out_valid && out_ch.closes_field == CLOSE_NONE)
  `CTP_ASSERT_NOW(a_ok_only_last, out_ch.valid && out_ch.parse_status == ST_OK, out_ch.is_final)

endmodule

// ===== design/ctp_classify.sv =====
`timescale 1ns / 1ps

module ctp_classify
  import ctp_pkg::*;
(
  input  logic [7:0] byte_i,
  output ctp_cls_t   cls_o
);

  logic special;

  always_comb begin
    special = byte_i inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, CH_SEMI,
                             8'h3A, CH_QUOTE, CH_SLASH, 8'h5B, 8'h5D, 8'h3F,
                             CH_EQ};
    cls_o.tok    = (byte_i > CH_SPACE) && (byte_i < CH_DEL) && !special;
    cls_o.ws     = (byte_i == CH_SPACE) || (byte_i inside {[8'h09:8'h0D]});
    cls_o.slash  = byte_i == CH_SLASH;
    cls_o.semi   = byte_i == CH_SEMI;
    cls_o.eq     = byte_i == CH_EQ;
    cls_o.quote  = byte_i == CH_QUOTE;
    cls_o.bslash = byte_i == CH_BSLASH;
    cls_o.crlf   = (byte_i == CH_CR) || (byte_i == CH_LF);
    cls_o.star   = byte_i == CH_STAR;
  end

endmodule

// ===== design/ctp_fsm.sv =====
`timescale 1ns / 1ps

module ctp_fsm
  import ctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  ctp_cls_t   cls_i,
  output ctp_res_t   res_o
);

  ctp_phase_t  phase_r, phase_nxt, ph;
  ctp_status_t err_r, err_nxt, nerr;
  ctp_role_t   role;
  ctp_close_t  closes;
  logic [7:0]  och;

  always_comb begin
    ph     = phase_r;
    nerr   = ST_BUSY;
    role   = ROLE_SKIP;
    och    = 8'h00;
    closes = CLOSE_NONE;
    err_nxt = err_r;

    if (err_r == ST_BUSY) begin
      case (phase_r)
        PH_LEAD: begin
          if (cls_i.ws) begin
          end else if (cls_i.tok) begin
            role = ROLE_TYPE; och = ctp_lower(byte_i); ph = PH_TYPE;
          end else nerr = ST_MEDIA;
        end
        PH_TYPE: begin
          if (cls_i.tok) begin
            role = ROLE_TYPE; och = ctp_lower(byte_i);
          end else if (cls_i.ws) ph = PH_TYPE_WS;
          else if (cls_i.slash) ph = PH_SUB_LEAD;
          else nerr = ST_MEDIA;
        end
        PH_TYPE_WS: begin
          if (cls_i.ws) begin
          end else if (cls_i.slash) ph = PH_SUB_LEAD;
          else nerr = ST_MEDIA;
        end
        PH_SUB_LEAD: begin
          if (cls_i.ws) begin
          end else if (cls_i.tok) begin
            role = ROLE_SUB; och = ctp_lower(byte_i); ph = PH_SUB;
          end else nerr = ST_MEDIA;
        end
        PH_SUB: begin
          if (cls_i.tok) begin
            role = ROLE_SUB; och = ctp_lower(byte_i);
          end else if (cls_i.ws) ph = PH_SUB_WS;
          else if (cls_i.semi) begin
            closes = CLOSE_MEDIA; ph = PH_PAR_LEAD;
          end else nerr = ST_MEDIA;
        end
        PH_SUB_WS: begin
          if (cls_i.ws) begin
          end else if (cls_i.semi) begin
            closes = CLOSE_MEDIA; ph = PH_PAR_LEAD;
          end else nerr = ST_MEDIA;
        end
        PH_PAR_LEAD, PH_KEY: begin
          if (cls_i.star) nerr = ST_PARAM;
          else if (cls_i.tok) begin
            role = ROLE_KEY; och = ctp_lower(byte_i); ph = PH_KEY;
          end else if (cls_i.ws) begin
            if (phase_r == PH_KEY) ph = PH_KEY_WS;
          end else if (cls_i.eq && phase_r == PH_KEY) ph = PH_VAL_LEAD;
          else nerr = ST_PARAM;
        end
        PH_KEY_WS: begin
          if (cls_i.ws) begin
          end else if (cls_i.eq) ph = PH_VAL_LEAD;
          else nerr = ST_PARAM;
        end
        PH_VAL_LEAD: begin
          if (cls_i.ws) begin
          end else if (cls_i.quote) ph = PH_QUOTED;
          else if (cls_i.tok) begin
            role = ROLE_VAL; och = byte_i; ph = PH_TOKVAL;
          end else nerr = ST_PARAM;
        end
        PH_TOKVAL: begin
          if (cls_i.tok) begin
            role = ROLE_VAL; och = byte_i;
          end else if (cls_i.ws) ph = PH_VAL_WS;
          else if (cls_i.semi) begin
            closes = CLOSE_PARAM; ph = PH_PAR_LEAD;
          end else nerr = ST_PARAM;
        end
        PH_QUOTED: begin
          if (cls_i.quote) ph = PH_VAL_WS;
          else if (cls_i.bslash) ph = PH_ESC;
          else if (cls_i.crlf) nerr = ST_PARAM;
          else begin
            role = ROLE_VAL; och = byte_i;
          end
        end
        PH_ESC: begin
          if (cls_i.crlf) nerr = ST_PARAM;
          else begin
            role = ROLE_VAL; och = byte_i; ph = PH_QUOTED;
          end
        end
        PH_VAL_WS: begin
          if (cls_i.ws) begin
          end else if (cls_i.semi) begin
            closes = CLOSE_PARAM; ph = PH_PAR_LEAD;
          end else nerr = ST_PARAM;
        end
        default: nerr = ST_PARAM;
      endcase
      if (nerr != ST_BUSY) begin
        err_nxt = nerr;
        role = ROLE_SKIP; och = 8'h00; closes = CLOSE_NONE;
      end
    end

    if (err_nxt == ST_BUSY && last_i) begin
      if (ph == PH_SUB || ph == PH_SUB_WS) closes = CLOSE_MEDIA;
      else if (ph == PH_TOKVAL || ph == PH_VAL_WS) closes = CLOSE_PARAM;
      else if (ph inside {PH_LEAD, PH_TYPE, PH_TYPE_WS, PH_SUB_LEAD}) err_nxt = ST_MEDIA;
      else if (ph != PH_PAR_LEAD) err_nxt = ST_PARAM;
      if (err_nxt != ST_BUSY) begin
        role = ROLE_SKIP; och = 8'h00; closes = CLOSE_NONE;
      end
    end

    res_o.och        = och;
    res_o.valid      = role != ROLE_SKIP;
    res_o.role       = role;
    res_o.closes     = closes;
    res_o.status     = (err_nxt != ST_BUSY) ? err_nxt : (last_i ? ST_OK : ST_BUSY);
    res_o.final_byte = last_i;

    phase_nxt = last_i ? PH_LEAD : ph;
  end

  // restart on the word after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      err_r   <= ST_BUSY;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      err_r   <= last_i ? ST_BUSY : err_nxt;
    end
  end

endmodule
